// ----- hdl/bspa_pkg.sv -----
// Shared constants, codes and control/status types for the bitmap slot pool allocator.
`timescale 1ns / 1ps

package bspa_pkg;

  // Fixed field widths of the item and result channels.
  localparam int HANDLE_W = 10;
  localparam int STATUS_W = 2;

  // Default pool geometry.
  localparam int DEF_SLOTS  = 16;
  localparam int DEF_ARENAS = 64;

  // The claimed flags are kept in rows of this many arenas.
  localparam int CLAIM_ROW_W = 32;
  localparam int CLAIM_ROW_B = 5;

  // Request codes.
  localparam logic CMD_FREE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNCLAIMED = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic alloc_head;
    logic alloc_fresh;
    logic div;
    logic rem;
    logic free_upd;
    logic free_link;
    logic grant;
    logic set_exhaust;
    logic set_unclaimed;
    logic load_out;
  } bspa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic head_nil;
    logic pool_full;
    logic out_of_pool;
    logic claimed;
    logic push_link;
    logic out_free;
  } bspa_sts_t;

endpackage

// ----- hdl/bitmap_slot_pool_allocator_top.sv -----
// Top level of the bitmap slot pool allocator: controller plus datapath.
// An alloc ends early when the pool is exhausted; a free ends early when its handle lies
// outside the pool, and takes an extra link step when it pushes an arena onto a non-empty list.
// The result is registered after the item's transfer, following the registered table reads
// and the link update order; a held result delays the next one.
// A new item is taken while the previous result still waits in the output register.
// Reset (synchronous, rst_n low) empties the list and marks every arena unclaimed at once.
`timescale 1ns / 1ps

module bitmap_slot_pool_allocator_top import bspa_pkg::*; #(
  parameter int SLOTS_PER_ARENA = DEF_SLOTS,
  parameter int ARENA_COUNT     = DEF_ARENAS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic [HANDLE_W-1:0] in_slot_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HANDLE_W-1:0] out_granted_handle,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_arena_taken,
  output logic                out_arena_released
);

  bspa_cmd_t cmd;
  bspa_sts_t sts;

  // Operation sequencer.
  bspa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Tables, list links and result registers.
  bspa_dpath #(
    .SLOTS_PER_ARENA (SLOTS_PER_ARENA),
    .ARENA_COUNT     (ARENA_COUNT)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_cmd),
    .in_slot_handle     (in_slot_handle),
    .cmd                (cmd),
    .sts                (sts),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_granted_handle (out_granted_handle),
    .out_status         (out_status),
    .out_arena_taken    (out_arena_taken),
    .out_arena_released (out_arena_released)
  );

endmodule

// ----- hdl/bspa_ctrl.sv -----
// Sequencing state machine of the slot allocator.
`timescale 1ns / 1ps

module bspa_ctrl import bspa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_stall,
  output bspa_cmd_t cmd,
  input  bspa_sts_t sts
);

  typedef enum logic [9:0] {
    S_IDLE       = 10'b00_0000_0001,
    S_ALOC_RD    = 10'b00_0000_0010,
    S_ALOC_HEAD  = 10'b00_0000_0100,
    S_ALOC_FRESH = 10'b00_0000_1000,
    S_GRANT      = 10'b00_0001_0000,
    S_FREE_DIV   = 10'b00_0010_0000,
    S_FREE_REM   = 10'b00_0100_0000,
    S_FREE_UPD   = 10'b00_1000_0000,
    S_FREE_LINK  = 10'b01_0000_0000,
    S_RESULT     = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // New items are taken only between operations.
  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (in_cmd == CMD_FREE) ? S_FREE_DIV : S_ALOC_RD;
        end
      end
      S_ALOC_RD: begin
        if (sts.pool_full) begin
          cmd.set_exhaust = 1'b1;
          state_nxt       = S_RESULT;
        end else if (sts.head_nil) begin
          state_nxt = S_ALOC_FRESH;
        end else begin
          state_nxt = S_ALOC_HEAD;
        end
      end
      S_ALOC_HEAD: begin
        cmd.alloc_head = 1'b1;
        state_nxt      = S_GRANT;
      end
      S_ALOC_FRESH: begin
        cmd.alloc_fresh = 1'b1;
        state_nxt       = S_GRANT;
      end
      S_GRANT: begin
        cmd.grant = 1'b1;
        state_nxt = S_RESULT;
      end
      S_FREE_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_FREE_REM;
      end
      S_FREE_REM: begin
        cmd.rem = 1'b1;
        if (sts.out_of_pool) begin
          cmd.set_unclaimed = 1'b1;
          state_nxt         = S_RESULT;
        end else begin
          state_nxt = S_FREE_UPD;
        end
      end
      S_FREE_UPD: begin
        cmd.free_upd = 1'b1;
        if (!sts.claimed) begin
          cmd.set_unclaimed = 1'b1;
          state_nxt         = S_RESULT;
        end else if (sts.push_link) begin
          state_nxt = S_FREE_LINK;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_FREE_LINK: begin
        cmd.free_link = 1'b1;
        state_nxt     = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/bspa_dpath.sv -----
// Datapath of the slot allocator: arena tables, partial list links and result registers.
`timescale 1ns / 1ps

module bspa_dpath import bspa_pkg::*; #(
  parameter int SLOTS_PER_ARENA = DEF_SLOTS,
  parameter int ARENA_COUNT     = DEF_ARENAS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_cmd,
  input  logic [HANDLE_W-1:0] in_slot_handle,
  input  bspa_cmd_t           cmd,
  output bspa_sts_t           sts,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [HANDLE_W-1:0] out_granted_handle,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_arena_taken,
  output logic                out_arena_released
);

  // Derived geometry.
  localparam int SW   = $clog2(SLOTS_PER_ARENA);
  localparam int SVW  = $clog2(SLOTS_PER_ARENA + 1);
  localparam int LW   = $clog2(ARENA_COUNT + 1);
  localparam int AIW  = (ARENA_COUNT > 1) ? $clog2(ARENA_COUNT) : 1;
  localparam int ROWS = (ARENA_COUNT + CLAIM_ROW_W - 1) / CLAIM_ROW_W;
  localparam int RIW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LAST_CNT = ARENA_COUNT - (ROWS - 1) * CLAIM_ROW_W;
  localparam logic [CLAIM_ROW_W-1:0] LAST_PAD = (LAST_CNT >= CLAIM_ROW_W) ? '0 :
      ~((CLAIM_ROW_W'(1) << LAST_CNT) - CLAIM_ROW_W'(1));

  // Reciprocal for splitting a handle into arena and slot; exact for all handles.
  localparam int K     = HANDLE_W + SW;
  localparam int RCW   = K + 1;
  localparam int RECIP = ((1 << K) + SLOTS_PER_ARENA - 1) / SLOTS_PER_ARENA;

  localparam logic [RCW-1:0]  RECIP_V = RCW'(RECIP);
  localparam logic [SVW-1:0]  SV      = SVW'(SLOTS_PER_ARENA);
  localparam logic [LW-1:0]   NIL     = LW'(ARENA_COUNT);
  localparam logic [RIW-1:0]  LAST_ROW = RIW'(ROWS - 1);

  // Item and work registers.
  logic                   cmd_free_r;
  logic [HANDLE_W-1:0]    handle_r;
  logic [HANDLE_W-1:0]    quo_r;
  logic [SW-1:0]          slot_r;
  logic [LW-1:0]          arena_r;
  logic [LW-1:0]          link_r;
  logic [LW-1:0]          head_r;
  logic [LW-1:0]          head_nxt;
  logic [ROWS-1:0]        row_full_r;
  logic [ROWS-1:0]        row_valid_r;
  logic [RIW-1:0]         crow_ra_r;

  // Result and output registers.
  logic [HANDLE_W-1:0]    res_granted_r;
  logic [STATUS_W-1:0]    res_status_r;
  logic                   res_taken_r;
  logic                   res_released_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [HANDLE_W-1:0]    out_granted_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic                   out_taken_r;
  logic                   out_released_r;

  // Per-arena tables and the claimed rows.
  logic [SLOTS_PER_ARENA-1:0] occ_mem   [ARENA_COUNT];
  logic [LW-1:0]              next_mem  [ARENA_COUNT];
  logic [LW-1:0]              prev_mem  [ARENA_COUNT];
  logic                       onl_mem   [ARENA_COUNT];
  logic [CLAIM_ROW_W-1:0]     claim_mem [ROWS];

  logic [SLOTS_PER_ARENA-1:0] occ_rd_r;
  logic [LW-1:0]              next_rd_r;
  logic [LW-1:0]              prev_rd_r;
  logic                       onl_rd_r;
  logic [CLAIM_ROW_W-1:0]     claim_rd_r;

  // Write ports.
  logic                       occ_we;
  logic [AIW-1:0]             occ_wa;
  logic [SLOTS_PER_ARENA-1:0] occ_wd;
  logic                       next_we;
  logic [AIW-1:0]             next_wa;
  logic [LW-1:0]              next_wd;
  logic                       prev_we;
  logic [AIW-1:0]             prev_wa;
  logic [LW-1:0]              prev_wd;
  logic                       onl_we;
  logic [AIW-1:0]             onl_wa;
  logic                       onl_wd;
  logic                       claim_we;
  logic [CLAIM_ROW_W-1:0]     claim_wd;

  // Combinational helpers.
  logic [AIW-1:0]             mem_ra;
  logic [RIW-1:0]             free_row;
  logic [RIW-1:0]             open_row;
  logic [RIW-1:0]             crow_ra;
  logic                       head_nil;
  logic [CLAIM_ROW_W-1:0]     row_eff;
  logic [CLAIM_ROW_W-1:0]     row_pad;
  logic [CLAIM_ROW_W-1:0]     row_occ;
  logic [CLAIM_ROW_B-1:0]     fresh_bit;
  logic [LW-1:0]              fresh_arena;
  logic [CLAIM_ROW_B-1:0]     row_bit;
  logic                       claimed;
  logic [SW-1:0]              first_open;
  logic [SLOTS_PER_ARENA-1:0] occ_set;
  logic                       occ_full;
  logic [SLOTS_PER_ARENA-1:0] occ_clr;
  logic                       occ_empty;
  logic                       free_unlink;
  logic                       free_push;
  logic [HANDLE_W+RCW-1:0]    quo_prod;
  logic [HANDLE_W-1:0]        quo_nxt;
  logic [HANDLE_W+SVW-1:0]    qs_prod;
  logic [HANDLE_W-1:0]        rem_val;
  logic [LW+SVW:0]            grant_sum;
  logic                       out_of_pool;

  // Read addresses: the item's arena for a free, the list head for an alloc.
  assign mem_ra   = cmd_free_r ? AIW'(quo_r) : AIW'(head_r);
  assign free_row = RIW'(quo_r >> CLAIM_ROW_B);
  assign crow_ra  = cmd_free_r ? free_row : open_row;
  assign head_nil = (head_r == NIL);

  // Lowest claimed row that still has an unclaimed arena.
  always_comb begin
    open_row = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!row_full_r[i]) open_row = RIW'(i);
    end
  end

  // Claimed row as read; rows never written read as all unclaimed.
  assign row_eff = row_valid_r[crow_ra_r] ? claim_rd_r : '0;
  assign row_pad = (crow_ra_r == LAST_ROW) ? LAST_PAD : '0;
  assign row_occ = row_eff | row_pad;

  // Lowest unclaimed arena within the row.
  always_comb begin
    fresh_bit = '0;
    for (int i = CLAIM_ROW_W - 1; i >= 0; i--) begin
      if (!row_occ[i]) fresh_bit = CLAIM_ROW_B'(i);
    end
  end

  assign fresh_arena = LW'({crow_ra_r, fresh_bit});
  assign row_bit     = CLAIM_ROW_B'(arena_r);
  assign claimed     = row_eff[row_bit];

  // Lowest free slot of the head arena.
  always_comb begin
    first_open = '0;
    for (int i = SLOTS_PER_ARENA - 1; i >= 0; i--) begin
      if (!occ_rd_r[i]) first_open = SW'(i);
    end
  end

  assign occ_set   = occ_rd_r | (SLOTS_PER_ARENA'(1) << first_open);
  assign occ_full  = &occ_set;
  assign occ_clr   = occ_rd_r & ~(SLOTS_PER_ARENA'(1) << slot_r);
  assign occ_empty = (occ_clr == '0);

  assign free_unlink = claimed && occ_empty && onl_rd_r;
  assign free_push   = claimed && !occ_empty && !onl_rd_r;

  // Handle split: arena by reciprocal multiply, slot as the remainder.
  assign quo_prod    = handle_r * RECIP_V;
  assign quo_nxt     = HANDLE_W'(quo_prod >> K);
  assign qs_prod     = quo_r * SV;
  assign rem_val     = handle_r - HANDLE_W'(qs_prod);
  assign out_of_pool = ({1'b0, quo_r} >= (HANDLE_W + 1)'(ARENA_COUNT));

  // Granted handle of the chosen arena and slot.
  assign grant_sum = arena_r * SV + (LW + SVW + 1)'(slot_r);

  // Status toward the controller.
  assign sts.head_nil    = head_nil;
  assign sts.pool_full   = head_nil && (&row_full_r);
  assign sts.out_of_pool = out_of_pool;
  assign sts.claimed     = claimed;
  assign sts.push_link   = free_push && !head_nil;
  assign sts.out_free    = !out_valid_r || !out_stall;

  // Table writes for each step of an operation.
  always_comb begin
    occ_we   = 1'b0;
    occ_wa   = AIW'(arena_r);
    occ_wd   = occ_clr;
    next_we  = 1'b0;
    next_wa  = AIW'(arena_r);
    next_wd  = NIL;
    prev_we  = 1'b0;
    prev_wa  = AIW'(arena_r);
    prev_wd  = NIL;
    onl_we   = 1'b0;
    onl_wa   = AIW'(arena_r);
    onl_wd   = 1'b0;
    claim_we = 1'b0;
    claim_wd = row_eff;
    head_nxt = head_r;
    if (cmd.alloc_head) begin
      // Take a slot in the head arena; a full arena leaves the list.
      occ_we = 1'b1;
      occ_wa = AIW'(head_r);
      occ_wd = occ_set;
      if (occ_full) begin
        onl_we   = 1'b1;
        onl_wa   = AIW'(head_r);
        onl_wd   = 1'b0;
        head_nxt = next_rd_r;
        if (next_rd_r != NIL) begin
          prev_we = 1'b1;
          prev_wa = AIW'(next_rd_r);
          prev_wd = NIL;
        end
      end
    end else if (cmd.alloc_fresh) begin
      // Claim a fresh arena, give it slot zero and make it the list head.
      occ_we   = 1'b1;
      occ_wa   = AIW'(fresh_arena);
      occ_wd   = SLOTS_PER_ARENA'(1);
      next_we  = 1'b1;
      next_wa  = AIW'(fresh_arena);
      next_wd  = NIL;
      prev_we  = 1'b1;
      prev_wa  = AIW'(fresh_arena);
      prev_wd  = NIL;
      onl_we   = 1'b1;
      onl_wa   = AIW'(fresh_arena);
      onl_wd   = 1'b1;
      claim_we = 1'b1;
      claim_wd = row_eff | (CLAIM_ROW_W'(1) << fresh_bit);
      head_nxt = fresh_arena;
    end else if (cmd.free_upd && claimed) begin
      occ_we = 1'b1;
      if (occ_empty) begin
        // Release the emptied arena and unlink it if it is listed.
        claim_we = 1'b1;
        claim_wd = row_eff & ~(CLAIM_ROW_W'(1) << row_bit);
        if (free_unlink) begin
          onl_we = 1'b1;
          onl_wd = 1'b0;
          if (head_r == arena_r) head_nxt = next_rd_r;
          if (prev_rd_r != NIL) begin
            next_we = 1'b1;
            next_wa = AIW'(prev_rd_r);
            next_wd = next_rd_r;
          end
          if (next_rd_r != NIL) begin
            prev_we = 1'b1;
            prev_wa = AIW'(next_rd_r);
            prev_wd = prev_rd_r;
          end
        end
      end else if (free_push) begin
        // Push the arena at the head; the old head's back link follows.
        next_we  = 1'b1;
        next_wd  = head_r;
        prev_we  = 1'b1;
        prev_wd  = NIL;
        onl_we   = 1'b1;
        onl_wd   = 1'b1;
        head_nxt = arena_r;
      end
    end else if (cmd.free_link) begin
      prev_we = 1'b1;
      prev_wa = AIW'(link_r);
      prev_wd = arena_r;
    end
  end

  // Arena tables: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
    occ_rd_r <= occ_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_r <= next_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd_r <= prev_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (onl_we) onl_mem[onl_wa] <= onl_wd;
    onl_rd_r <= onl_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (claim_we) claim_mem[crow_ra_r] <= claim_wd;
    claim_rd_r <= claim_mem[crow_ra];
    crow_ra_r  <= crow_ra;
  end

  // Output register is free again once its transfer completes.
  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && out_stall);

  // Control state: list head, row summaries and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NIL;
      row_full_r  <= '0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      if (claim_we) begin
        row_valid_r[crow_ra_r] <= 1'b1;
        row_full_r[crow_ra_r]  <= &(claim_wd | row_pad);
      end
    end
  end

  // Item capture and work registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_free_r <= (in_cmd == CMD_FREE);
      handle_r   <= in_slot_handle;
    end
    if (cmd.div) quo_r <= quo_nxt;
    if (cmd.rem) begin
      slot_r  <= SW'(rem_val);
      arena_r <= LW'(quo_r);
    end
    if (cmd.alloc_head) begin
      slot_r  <= first_open;
      arena_r <= head_r;
    end
    if (cmd.alloc_fresh) begin
      slot_r  <= '0;
      arena_r <= fresh_arena;
    end
    if (cmd.free_upd) link_r <= head_r;
  end

  // Result fields of the item at work.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      res_granted_r  <= '0;
      res_status_r   <= ST_OK;
      res_taken_r    <= 1'b0;
      res_released_r <= 1'b0;
    end else begin
      if (cmd.set_exhaust) res_status_r <= ST_EXHAUSTED;
      if (cmd.set_unclaimed) res_status_r <= ST_UNCLAIMED;
      if (cmd.alloc_fresh) res_taken_r <= 1'b1;
      if (cmd.free_upd && claimed && occ_empty) res_released_r <= 1'b1;
      if (cmd.grant) res_granted_r <= HANDLE_W'(grant_sum);
    end
  end

  // Output register, loaded only when empty or being drained.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_granted_r  <= res_granted_r;
      out_status_r   <= res_status_r;
      out_taken_r    <= res_taken_r;
      out_released_r <= res_released_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted_handle = out_granted_r;
  assign out_status         = out_status_r;
  assign out_arena_taken    = out_taken_r;
  assign out_arena_released = out_released_r;

endmodule
